### rtl/mi3_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mi3_pkg
// Shared widths, latencies, cofactor operand tables and types for the
// 3x3 adjugate matrix inverse.
// ----------------------------------------------------------------------------
package mi3_pkg;

    localparam int ELEM_W   = 32;   // input and inverse element width
    localparam int ADJ_W    = 64;   // exact 2x2 cofactor width
    localparam int TERM_W   = 96;   // element times cofactor
    localparam int DSUM_W   = 98;   // exact determinant
    localparam int MAG_W    = 96;   // determinant magnitude
    localparam int LEN_W    = 7;    // bit length of the magnitude, 0 to 96
    localparam int REM_W    = 97;   // divider remainder
    localparam int Q_W      = 33;   // reciprocal width
    localparam int PROD_W   = 97;   // |adj| times reciprocal
    localparam int DET_W    = 64;   // determinant output width
    localparam int N_ELEM   = 9;

    // pipeline depths of each section
    localparam int COF_LAT   = 2;
    localparam int DET_LAT   = 7;
    localparam int RECIP_LAT = Q_W;
    localparam int LANE_LAT  = 4;
    localparam int TOTAL_LAT = COF_LAT + DET_LAT + RECIP_LAT + LANE_LAT;

    typedef logic [3:0] idx_t;

    // element order: a00 a01 a02 a10 a11 a12 a20 a21 a22
    // adjugate entry k is x*w - y*z of the elements below
    localparam idx_t COF_X [N_ELEM] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
    localparam idx_t COF_Y [N_ELEM] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
    localparam idx_t COF_Z [N_ELEM] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};
    localparam idx_t COF_W [N_ELEM] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};

    // determinant facts handed to the scaling lanes
    typedef struct packed {
        logic             dneg;
        logic             sing;
        logic [LEN_W-1:0] len;
    } dinfo_t;

endpackage
`default_nettype wire

### rtl/matrix_inverse_3x3.sv
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one matrix per cycle; busy is always low, set by the fully
// pipelined 33-stage reciprocal divider and the nine cofactor/scale lanes.
// Reset clears only the valid line; no result is strobed until refilled.
// ----------------------------------------------------------------------------
// matrix_inverse_3x3
// 3x3 Q-format matrix inverse by adjugate and one shared reciprocal.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3 #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic signed [mi3_pkg::ELEM_W-1:0] a00,
    input  wire logic signed [mi3_pkg::ELEM_W-1:0] a01,
    input  wire logic signed [mi3_pkg::ELEM_W-1:0] a02,
    input  wire logic signed [mi3_pkg::ELEM_W-1:0] a10,
    input  wire logic signed [mi3_pkg::ELEM_W-1:0] a11,
    input  wire logic signed [mi3_pkg::ELEM_W-1:0] a12,
    input  wire logic signed [mi3_pkg::ELEM_W-1:0] a20,
    input  wire logic signed [mi3_pkg::ELEM_W-1:0] a21,
    input  wire logic signed [mi3_pkg::ELEM_W-1:0] a22,
    output logic                                   done,
    output logic      signed [mi3_pkg::ELEM_W-1:0] r00,
    output logic      signed [mi3_pkg::ELEM_W-1:0] r01,
    output logic      signed [mi3_pkg::ELEM_W-1:0] r02,
    output logic      signed [mi3_pkg::ELEM_W-1:0] r10,
    output logic      signed [mi3_pkg::ELEM_W-1:0] r11,
    output logic      signed [mi3_pkg::ELEM_W-1:0] r12,
    output logic      signed [mi3_pkg::ELEM_W-1:0] r20,
    output logic      signed [mi3_pkg::ELEM_W-1:0] r21,
    output logic      signed [mi3_pkg::ELEM_W-1:0] r22,
    output logic      signed [mi3_pkg::DET_W-1:0]  determinant,
    output logic                                   singular
);

    localparam int NE      = mi3_pkg::N_ELEM;
    localparam int ADJ_W   = mi3_pkg::ADJ_W;
    localparam int INFO_W  = $bits(mi3_pkg::dinfo_t);
    localparam int ADJ_DLY = mi3_pkg::DET_LAT + mi3_pkg::RECIP_LAT;
    localparam int OUT_DLY = mi3_pkg::RECIP_LAT + mi3_pkg::LANE_LAT;

    logic signed [mi3_pkg::ELEM_W-1:0] elem [NE];
    logic signed [ADJ_W-1:0]           adj [NE];
    logic [NE*ADJ_W-1:0]               adj_bus, adj_bus_d;
    logic [3*mi3_pkg::ELEM_W-1:0]      acol_d;
    logic signed [mi3_pkg::ELEM_W-1:0] a_col [3];
    logic signed [ADJ_W-1:0]           adj_col [3];
    logic [mi3_pkg::MAG_W-1:0]         norm;
    logic signed [mi3_pkg::DET_W-1:0]  det_val;
    mi3_pkg::dinfo_t                   info, info_d;
    logic [mi3_pkg::Q_W-1:0]           q;
    logic [mi3_pkg::DET_W:0]           detsing_d;
    logic signed [mi3_pkg::ELEM_W-1:0] res [NE];
    logic [mi3_pkg::TOTAL_LAT-1:0]     vld_reg, vld_next;

    assign elem = '{a00, a01, a02, a10, a11, a12, a20, a21, a22};

    // cofactor lanes
    genvar k;
    generate
        for (k = 0; k < NE; k++)
        begin : g_cof
            mi3_cof_lane u_cof (
                .clk (clk),
                .x   (elem[mi3_pkg::COF_X[k]]),
                .y   (elem[mi3_pkg::COF_Y[k]]),
                .z   (elem[mi3_pkg::COF_Z[k]]),
                .w   (elem[mi3_pkg::COF_W[k]]),
                .adj (adj[k])
            );
            assign adj_bus[k*ADJ_W +: ADJ_W] = adj[k];
        end
    endgenerate

    // first column, aligned with the cofactors
    mi3_delay #(.WIDTH(3 * mi3_pkg::ELEM_W), .DEPTH(mi3_pkg::COF_LAT)) u_acol_dly (
        .clk  (clk),
        .din  ({a00, a10, a20}),
        .dout (acol_d)
    );

    assign a_col   = '{$signed(acol_d[95:64]), $signed(acol_d[63:32]), $signed(acol_d[31:0])};
    assign adj_col = '{adj[0], adj[1], adj[2]};

    // determinant merge
    mi3_det #(.FRAC_BITS(FRAC_BITS)) u_det (
        .clk     (clk),
        .a_col   (a_col),
        .adj_col (adj_col),
        .norm    (norm),
        .det_val (det_val),
        .info    (info)
    );

    // shared reciprocal
    mi3_recip u_recip (
        .clk  (clk),
        .norm (norm),
        .q    (q)
    );

    // side data alignment
    mi3_delay #(.WIDTH(INFO_W), .DEPTH(mi3_pkg::RECIP_LAT)) u_info_dly (
        .clk  (clk),
        .din  (info),
        .dout (info_d)
    );

    mi3_delay #(.WIDTH(NE * ADJ_W), .DEPTH(ADJ_DLY)) u_adj_dly (
        .clk  (clk),
        .din  (adj_bus),
        .dout (adj_bus_d)
    );

    mi3_delay #(.WIDTH(mi3_pkg::DET_W + 1), .DEPTH(OUT_DLY)) u_det_dly (
        .clk  (clk),
        .din  ({info.sing, det_val}),
        .dout (detsing_d)
    );

    // scaling lanes
    generate
        for (k = 0; k < NE; k++)
        begin : g_scale
            mi3_scale_lane #(.FRAC_BITS(FRAC_BITS)) u_scale (
                .clk  (clk),
                .adj  ($signed(adj_bus_d[k*ADJ_W +: ADJ_W])),
                .q    (q),
                .info (info_d),
                .res  (res[k])
            );
        end
    endgenerate

    // valid line for the done strobe
    assign vld_next = {vld_reg[mi3_pkg::TOTAL_LAT-2:0], start};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign busy        = 1'b0;
    assign done        = vld_reg[mi3_pkg::TOTAL_LAT-1];
    assign r00         = res[0];
    assign r01         = res[1];
    assign r02         = res[2];
    assign r10         = res[3];
    assign r11         = res[4];
    assign r12         = res[5];
    assign r20         = res[6];
    assign r21         = res[7];
    assign r22         = res[8];
    assign determinant = detsing_d[mi3_pkg::DET_W-1:0];
    assign singular    = detsing_d[mi3_pkg::DET_W];

endmodule
`default_nettype wire

### rtl/mi3_delay.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mi3_delay
// Fixed-length register line that keeps side data aligned with the pipe.
// ----------------------------------------------------------------------------
module mi3_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic [WIDTH-1:0] din,
    output logic      [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] line_reg [DEPTH];

    // shift one stage per clock
    always_ff @(posedge clk)
    begin
        line_reg[0] <= din;
        for (int i = 1; i < DEPTH; i++)
        begin
            line_reg[i] <= line_reg[i-1];
        end
    end

    assign dout = line_reg[DEPTH-1];

endmodule
`default_nettype wire

### rtl/mi3_cof_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mi3_cof_lane
// One cofactor lane: x*w - y*z, exact, two stages.
// ----------------------------------------------------------------------------
module mi3_cof_lane (
    input  wire logic                              clk,
    input  wire logic signed [mi3_pkg::ELEM_W-1:0] x,
    input  wire logic signed [mi3_pkg::ELEM_W-1:0] y,
    input  wire logic signed [mi3_pkg::ELEM_W-1:0] z,
    input  wire logic signed [mi3_pkg::ELEM_W-1:0] w,
    output logic      signed [mi3_pkg::ADJ_W-1:0]  adj
);

    logic signed [mi3_pkg::ADJ_W-1:0] pxw_next, pyz_next;
    logic signed [mi3_pkg::ADJ_W-1:0] pxw_reg, pyz_reg, adj_reg;

    // two products
    assign pxw_next = x * w;
    assign pyz_next = y * z;

    // products then difference
    always_ff @(posedge clk)
    begin
        pxw_reg <= pxw_next;
        pyz_reg <= pyz_next;
        adj_reg <= pxw_reg - pyz_reg;
    end

    assign adj = adj_reg;

endmodule
`default_nettype wire

### rtl/mi3_det.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mi3_det
// Merge section: determinant from the first column cofactors, its floor-shifted
// and saturated output value, its bit length and the normalized magnitude.
// ----------------------------------------------------------------------------
module mi3_det #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                              clk,
    input  wire logic signed [mi3_pkg::ELEM_W-1:0] a_col   [3],
    input  wire logic signed [mi3_pkg::ADJ_W-1:0]  adj_col [3],
    output logic             [mi3_pkg::MAG_W-1:0]  norm,
    output logic      signed [mi3_pkg::DET_W-1:0]  det_val,
    output mi3_pkg::dinfo_t                        info
);

    localparam int SHR = 2 * FRAC_BITS;
    localparam int NGRP = mi3_pkg::MAG_W / 16;

    typedef struct packed {
        logic                       dneg;
        logic                       sing;
        logic [mi3_pkg::DET_W-1:0]  detv;
    } side_t;

    logic signed [64:0]                  plo_next [3], plo_reg [3];
    logic signed [63:0]                  phi_next [3], phi_reg [3];
    logic signed [mi3_pkg::TERM_W-1:0]   term_next [3], term_reg [3];
    logic signed [mi3_pkg::DSUM_W-1:0]   dsum_reg;
    logic signed [mi3_pkg::DSUM_W-1:0]   dabs, dsh;
    side_t                               side_next, side4_reg, side5_reg, side6_reg, side7_reg;
    logic [mi3_pkg::MAG_W-1:0]           mag4_reg, mag5_reg, mag6_reg, norm_reg;
    logic [NGRP-1:0]                     nz_next, nz_reg;
    logic [3:0]                          pos_next [NGRP], pos_reg [NGRP];
    logic [mi3_pkg::LEN_W-1:0]           len_next, len6_reg, len7_reg;
    logic                                fits;

    // split each element times cofactor into two narrow products
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            plo_next[k]  = a_col[k] * $signed({1'b0, adj_col[k][31:0]});
            phi_next[k]  = a_col[k] * $signed(adj_col[k][63:32]);
            term_next[k] = $signed({phi_reg[k], 32'd0}) + 96'(plo_reg[k]);
        end
    end

    // sign, magnitude, singular flag and floor-shifted determinant
    always_comb
    begin
        dabs = dsum_reg[mi3_pkg::DSUM_W-1] ? -dsum_reg : dsum_reg;
        dsh  = dsum_reg >>> SHR;
        fits = (&dsh[mi3_pkg::DSUM_W-1:63]) | ~(|dsh[mi3_pkg::DSUM_W-1:63]);
        side_next.dneg = dsum_reg[mi3_pkg::DSUM_W-1];
        side_next.sing = (dsum_reg == '0);
        if (fits)
        begin
            side_next.detv = dsh[63:0];
        end
        else if (dsum_reg[mi3_pkg::DSUM_W-1])
        begin
            side_next.detv = {1'b1, 63'd0};
        end
        else
        begin
            side_next.detv = {1'b0, {63{1'b1}}};
        end
    end

    // leading one inside each 16-bit group
    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            nz_next[g]  = |mag4_reg[16*g +: 16];
            pos_next[g] = 4'd0;
            for (int b = 0; b < 16; b++)
            begin
                if (mag4_reg[16*g + b])
                begin
                    pos_next[g] = 4'(b);
                end
            end
        end
    end

    // merge the groups into the bit length
    always_comb
    begin
        len_next = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            if (nz_reg[g])
            begin
                len_next = 7'(16 * g) + 7'(pos_reg[g]) + 7'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        plo_reg   <= plo_next;
        phi_reg   <= phi_next;
        term_reg  <= term_next;
        dsum_reg  <= 98'(term_reg[0]) + 98'(term_reg[1]) + 98'(term_reg[2]);
        side4_reg <= side_next;
        mag4_reg  <= dabs[mi3_pkg::MAG_W-1:0];
        side5_reg <= side4_reg;
        mag5_reg  <= mag4_reg;
        nz_reg    <= nz_next;
        pos_reg   <= pos_next;
        side6_reg <= side5_reg;
        mag6_reg  <= mag5_reg;
        len6_reg  <= len_next;
        side7_reg <= side6_reg;
        len7_reg  <= len6_reg;
        norm_reg  <= mag6_reg << (7'd96 - len6_reg);
    end

    assign norm      = norm_reg;
    assign det_val   = side7_reg.detv;
    assign info.dneg = side7_reg.dneg;
    assign info.sing = side7_reg.sing;
    assign info.len  = len7_reg;

endmodule
`default_nettype wire

### rtl/mi3_recip.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mi3_recip
// Pipelined restoring divider: q = floor(2^127 / norm), one quotient bit
// per stage, norm has its top bit set.
// ----------------------------------------------------------------------------
module mi3_recip (
    input  wire logic                       clk,
    input  wire logic [mi3_pkg::MAG_W-1:0]  norm,
    output logic      [mi3_pkg::Q_W-1:0]    q
);

    localparam int NST = mi3_pkg::Q_W;

    logic [mi3_pkg::REM_W-1:0] rem_reg [NST-1];
    logic [mi3_pkg::MAG_W-1:0] div_reg [NST-1];
    logic [mi3_pkg::Q_W-1:0]   q_reg   [NST];

    genvar st;
    generate
        for (st = 0; st < NST; st++)
        begin : g_stage
            logic [mi3_pkg::REM_W-1:0] rem_in, rem_dif;
            logic [mi3_pkg::MAG_W-1:0] div_in;
            logic [mi3_pkg::Q_W-1:0]   q_in;
            logic                      ge;

            // stage inputs: first stage starts from 2^95
            if (st == 0)
            begin : g_first
                assign rem_in = {2'b01, 95'd0};
                assign div_in = norm;
                assign q_in   = '0;
            end
            else
            begin : g_next
                assign rem_in = rem_reg[st-1];
                assign div_in = div_reg[st-1];
                assign q_in   = q_reg[st-1];
            end

            // compare and subtract
            assign ge      = rem_in >= {1'b0, div_in};
            assign rem_dif = ge ? (rem_in - {1'b0, div_in}) : rem_in;

            always_ff @(posedge clk)
            begin
                q_reg[st] <= {q_in[mi3_pkg::Q_W-2:0], ge};
            end

            if (st < NST - 1)
            begin : g_carry
                always_ff @(posedge clk)
                begin
                    rem_reg[st] <= {rem_dif[mi3_pkg::REM_W-2:0], 1'b0};
                    div_reg[st] <= div_in;
                end
            end
        end
    endgenerate

    assign q = q_reg[NST-1];

endmodule
`default_nettype wire

### rtl/mi3_scale_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mi3_scale_lane
// One inverse entry: |adj| times the shared reciprocal, scaled, signed,
// saturated to 32 bits, zero when the matrix is singular.
// ----------------------------------------------------------------------------
module mi3_scale_lane #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                              clk,
    input  wire logic signed [mi3_pkg::ADJ_W-1:0]  adj,
    input  wire logic        [mi3_pkg::Q_W-1:0]    q,
    input  wire mi3_pkg::dinfo_t                   info,
    output logic      signed [mi3_pkg::ELEM_W-1:0] res
);

    localparam int SHIFT_BIAS = 31 - 2 * FRAC_BITS;

    logic [mi3_pkg::ADJ_W-1:0]   amag;
    logic [64:0]                 plo_reg, phi_reg;
    logic [mi3_pkg::PROD_W-1:0]  m_reg, val_next, val_reg, mclamp;
    logic                        neg1_reg, neg2_reg, neg3_reg;
    logic                        sing1_reg, sing2_reg, sing3_reg;
    logic [mi3_pkg::LEN_W-1:0]   len1_reg, len2_reg;
    logic signed [8:0]           sh;
    logic [8:0]                  lsh;
    logic [32:0]                 lim;
    logic [31:0]                 mag32;
    logic [mi3_pkg::ELEM_W-1:0]  res_next, res_reg;

    assign amag = adj[mi3_pkg::ADJ_W-1] ? (~adj + 64'd1) : adj;

    // scale by 2^-(len + 31 - 2F), left when negative with an early clamp
    always_comb
    begin
        sh     = $signed({2'b00, len2_reg}) + 9'(SHIFT_BIAS);
        lsh    = 9'(-sh);
        mclamp = (m_reg[mi3_pkg::PROD_W-1:40] != '0) ? (97'd1 << 40) : m_reg;
        if (sh[8])
        begin
            val_next = mclamp << lsh;
        end
        else
        begin
            val_next = m_reg >> sh;
        end
    end

    // saturate and apply sign
    always_comb
    begin
        lim   = neg3_reg ? {1'b0, 1'b1, 31'd0} : {2'b00, {31{1'b1}}};
        mag32 = (val_reg > 97'(lim)) ? lim[31:0] : val_reg[31:0];
        if (sing3_reg)
        begin
            res_next = '0;
        end
        else if (neg3_reg)
        begin
            res_next = -mag32;
        end
        else
        begin
            res_next = mag32;
        end
    end

    always_ff @(posedge clk)
    begin
        plo_reg   <= 65'(amag[31:0]) * 65'(q);
        phi_reg   <= 65'(amag[63:32]) * 65'(q);
        neg1_reg  <= adj[mi3_pkg::ADJ_W-1] ^ info.dneg;
        sing1_reg <= info.sing;
        len1_reg  <= info.len;
        m_reg     <= {phi_reg, 32'd0} + 97'(plo_reg);
        neg2_reg  <= neg1_reg;
        sing2_reg <= sing1_reg;
        len2_reg  <= len1_reg;
        val_reg   <= val_next;
        neg3_reg  <= neg2_reg;
        sing3_reg <= sing2_reg;
        res_reg   <= res_next;
    end

    assign res = res_reg;

endmodule
`default_nettype wire

### sim/matrix_inverse_3x3_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_inverse_3x3_test
// Drives 3x3 Q16.16 matrices into the adjugate inverse and checks every
// inverse element, the determinant and the singular flag against an
// in-bench model built on wide exact arithmetic.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3_test;

    localparam int FRAC     = 16;
    localparam int LAT      = mi3_pkg::TOTAL_LAT;
    localparam int WD_LIMIT = 2000;

    typedef logic signed [mi3_pkg::ELEM_W-1:0] elem_t;

    typedef struct {
        elem_t                            r [9];
        logic signed [mi3_pkg::DET_W-1:0] det;
        logic                             sing;
    } inverse_t;

    logic  clk;
    logic  rst_n;
    logic  start;
    logic  busy;
    elem_t a [9];
    logic  done;
    elem_t r [9];
    logic signed [63:0] determinant;
    logic  singular;

    inverse_t pending_inverses [$];
    int       send_idle_pct;
    int       wd_count;
    bit       failed;

    matrix_inverse_3x3 #(.FRAC_BITS(FRAC)) u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .a00(a[0]), .a01(a[1]), .a02(a[2]),
        .a10(a[3]), .a11(a[4]), .a12(a[5]),
        .a20(a[6]), .a21(a[7]), .a22(a[8]),
        .done(done),
        .r00(r[0]), .r01(r[1]), .r02(r[2]),
        .r10(r[3]), .r11(r[4]), .r12(r[5]),
        .r20(r[6]), .r21(r[7]), .r22(r[8]),
        .determinant(determinant), .singular(singular)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // inverse by adjugate with exact wide arithmetic
    function automatic inverse_t invert(input elem_t m [9]);
        inverse_t            res;
        logic signed [63:0]  adj [9];
        logic signed [127:0] dexact;
        logic signed [127:0] dshift;
        logic [127:0]        mag;
        logic [127:0]        recip;
        logic [191:0]        prod;
        logic [63:0]         lim;
        int                  len;
        int                  sh;
        bit                  neg;
        adj[0] = 64'(m[4]) * m[8] - 64'(m[5]) * m[7];
        adj[1] = 64'(m[2]) * m[7] - 64'(m[1]) * m[8];
        adj[2] = 64'(m[1]) * m[5] - 64'(m[2]) * m[4];
        adj[3] = 64'(m[5]) * m[6] - 64'(m[3]) * m[8];
        adj[4] = 64'(m[0]) * m[8] - 64'(m[2]) * m[6];
        adj[5] = 64'(m[2]) * m[3] - 64'(m[0]) * m[5];
        adj[6] = 64'(m[3]) * m[7] - 64'(m[4]) * m[6];
        adj[7] = 64'(m[1]) * m[6] - 64'(m[0]) * m[7];
        adj[8] = 64'(m[0]) * m[4] - 64'(m[1]) * m[3];
        dexact = 128'(m[0]) * adj[0] + 128'(m[3]) * adj[1] + 128'(m[6]) * adj[2];
        if (dexact == 0)
        begin
            foreach (res.r[i]) res.r[i] = '0;
            res.det  = '0;
            res.sing = 1'b1;
            return res;
        end
        res.sing = 1'b0;
        dshift = dexact >>> (2 * FRAC);
        if (dshift > 128'sh7FFFFFFFFFFFFFFF)
            res.det = 64'sh7FFFFFFFFFFFFFFF;
        else if (dshift < -128'sh8000000000000000)
            res.det = 64'sh8000000000000000;
        else
            res.det = dshift[63:0];
        mag = dexact < 0 ? -dexact : dexact;
        len = 0;
        for (int i = 0; i < 128; i++)
            if (mag[i]) len = i + 1;
        recip = (128'd1 << (len + 31)) / mag;
        sh = len + 31 - 2 * FRAC;
        for (int i = 0; i < 9; i++)
        begin
            neg  = (adj[i] < 0) != (dexact < 0);
            prod = 192'(adj[i] < 0 ? -adj[i] : adj[i]) * recip;
            if (sh >= 0)
                prod = prod >> sh;
            else
                prod = prod << (-sh);
            lim = neg ? 64'h80000000 : 64'h7FFFFFFF;
            if (prod > 192'(lim)) prod = 192'(lim);
            res.r[i] = neg ? -prod[31:0] : prod[31:0];
        end
        return res;
    endfunction

    // sends one matrix beat with a random lead-in gap, start stays high after it
    task automatic send_matrix(input elem_t m [9]);
        while ($urandom_range(99) < send_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        foreach (m[i]) a[i] <= m[i];
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_inverses.push_back(invert(m));
    endtask

    // checks each done beat against the oldest predicted inverse
    always @(posedge clk)
    begin
        inverse_t want;
        if (rst_n && done)
        begin
            if (pending_inverses.size() == 0)
            begin
                $error("unexpected result beat");
                failed = 1'b1;
            end
            else
            begin
                want = pending_inverses.pop_front();
                for (int i = 0; i < 9; i++)
                    if (r[i] !== want.r[i])
                    begin
                        $error("r%0d%0d expected %0d got %0d", i / 3, i % 3,
                               want.r[i], r[i]);
                        failed = 1'b1;
                    end
                if (determinant !== want.det)
                begin
                    $error("determinant expected %0d got %0d", want.det, determinant);
                    failed = 1'b1;
                end
                if (singular !== want.sing)
                begin
                    $error("singular expected %0d got %0d", want.sing, singular);
                    failed = 1'b1;
                end
            end
        end
    end

    // watchdog on cycles without any accepted beat
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            wd_count <= 0;
        else
            wd_count <= wd_count + 1;
        if (wd_count >= WD_LIMIT)
        begin
            $display("matrix_inverse_3x3 verification failed");
            $finish;
        end
    end

    function automatic elem_t rand_elem();
        case ($urandom_range(5))
            0: return elem_t'($urandom);
            1: return elem_t'($urandom_range(4) << FRAC) - elem_t'(2 << FRAC);
            2: return elem_t'(int'($urandom_range(8191)) - 4096);
            3: return $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
            default: return elem_t'(int'($urandom_range(1 << 20)) - (1 << 19));
        endcase
    endfunction

    task automatic test_directed();
        elem_t m [9];
        // identity
        m = '{32'sh10000, 0, 0, 0, 32'sh10000, 0, 0, 0, 32'sh10000};
        send_matrix(m);
        // all zero, singular
        m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
        send_matrix(m);
        // repeated rows, singular
        m = '{1, 2, 3, 1, 2, 3, 7, 8, 9};
        send_matrix(m);
        // extremes of the fields
        foreach (m[i]) m[i] = 32'sh7FFFFFFF;
        send_matrix(m);
        foreach (m[i]) m[i] = 32'sh80000000;
        send_matrix(m);
        m = '{32'sh80000000, 0, 0, 0, 32'sh80000000, 0, 0, 0, 32'sh80000000};
        send_matrix(m);
        m = '{32'sh7FFFFFFF, 0, 0, 0, 32'sh7FFFFFFF, 0, 0, 0, 32'sh80000000};
        send_matrix(m);
        // tiny determinant, positive and negative
        m = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
        send_matrix(m);
        m = '{-1, 0, 0, 0, 1, 0, 0, 0, 1};
        send_matrix(m);
        // scaled diagonal, a permutation and two general matrices
        m = '{32'sh20000, 0, 0, 0, -32'sh40000, 0, 0, 0, 32'sh8000};
        send_matrix(m);
        m = '{0, 32'sh10000, 0, 0, 0, 32'sh10000, 32'sh10000, 0, 0};
        send_matrix(m);
        m = '{32'sh30000, 32'sh10000, -32'sh20000, 32'sh10000, 32'sh20000,
              32'sh50000, -32'sh10000, 32'sh40000, 32'sh10000};
        send_matrix(m);
        m = '{32'sh7FFFFFFF, 32'sh80000000, 1, -1, 32'sh7FFFFFFF, 0,
              32'sh80000000, 1, 32'sh7FFFFFFF};
        send_matrix(m);
    endtask

    task automatic test_random(input int count, input int idle_pct);
        elem_t m [9];
        send_idle_pct = idle_pct;
        repeat (count)
        begin
            foreach (m[i]) m[i] = rand_elem();
            // occasional singular by a copied row
            if ($urandom_range(15) == 0)
            begin
                m[6] = m[0]; m[7] = m[1]; m[8] = m[2];
            end
            send_matrix(m);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_inverses.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        failed        = 1'b0;
        wd_count      = 0;
        send_idle_pct = 0;
        rst_n         = 1'b0;
        start         = 1'b0;
        foreach (a[i]) a[i] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random(400, 0);
        drain();
        test_random(400, 58);
        test_random(350, 0);
        test_random(380, 20);
        drain();
        repeat (LAT + 10) @(posedge clk);
        if (!failed)
            $display("matrix_inverse_3x3 verification clean");
        else
            $display("matrix_inverse_3x3 verification failed");
        $finish;
    end

endmodule
